FILE: sv/world_point_perspective_projection_defines.svh
// Assertion macros shared by the perspective projection checkers.
`ifndef WORLD_POINT_PERSPECTIVE_PROJECTION_DEFINES_SVH
`define WORLD_POINT_PERSPECTIVE_PROJECTION_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define WPPP_ASSERT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication, disabled while reset is held.
`define WPPP_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

FILE: sv/wppp_pkg.sv
// Shared constants, types and helper functions of the perspective projection block.
package wppp_pkg;

  // Field and datapath widths.
  localparam int CW        = 32;
  localparam int FB        = 16;
  localparam int AXIS_W    = 18;
  localparam int AXIS_FRAC = 16;
  localparam int AXES_W    = 3 * AXIS_W;
  localparam int NEAR_W    = CW - 1;
  localparam int DEPTH_W   = CW - 1;
  localparam int PLANE_W   = 64;
  localparam int SIZE_W    = 32;
  localparam int CFG_W     = 64;
  localparam int DIFF_W    = CW + 1;
  localparam int PROD_W    = DIFF_W + AXIS_W;
  localparam int DOT_W     = PROD_W + 2;
  localparam int MAG_W     = DOT_W - 1;
  localparam int DEP_QW    = AXIS_FRAC + FB;
  localparam int MUL_W     = MAG_W + DEPTH_W + 1;
  localparam int NDC_QW    = CW;
  localparam int NDC_HW    = MUL_W - NDC_QW;
  localparam int NDC_DW    = SIZE_W + AXIS_FRAC;

  // Reset values of the configuration registers.
  localparam logic [AXIS_W-1:0]  AXIS_ONE    = AXIS_W'(1) << AXIS_FRAC;
  localparam logic [AXES_W-1:0]  FORWARD_RST = {{(2 * AXIS_W){1'b0}}, AXIS_ONE};
  localparam logic [AXES_W-1:0]  UP_RST      = {{AXIS_W{1'b0}}, AXIS_ONE, {AXIS_W{1'b0}}};
  localparam logic [AXES_W-1:0]  RIGHT_RST   = {AXIS_ONE, {(2 * AXIS_W){1'b0}}};
  localparam logic [NEAR_W-1:0]  NEAR_RST    = NEAR_W'(1) << FB;
  localparam logic [SIZE_W-1:0]  SIZE_RST    = SIZE_W'(2) << FB;
  localparam logic [PLANE_W-1:0] PLANE_RST   = {SIZE_RST, SIZE_RST};
  localparam logic [CW-1:0]      NDC_HALF    = CW'(1) << (CW - 1);

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_ORIGIN_X,
    CFG_ORIGIN_Y,
    CFG_ORIGIN_Z,
    CFG_FORWARD,
    CFG_UP,
    CFG_RIGHT,
    CFG_NEAR,
    CFG_PLANE
  } cfg_idx_t;

  typedef struct packed {
    logic signed [CW-1:0] point_x;
    logic signed [CW-1:0] point_y;
    logic signed [CW-1:0] point_z;
  } in_t;

  typedef struct packed {
    logic signed [CW-1:0] ndc_x;
    logic signed [CW-1:0] ndc_y;
    logic [DEPTH_W-1:0]   depth;
    logic                 culled;
  } out_t;

  // Front end results: forward length and the two screen dot products.
  typedef struct packed {
    logic                    culled;
    logic [MAG_W-1:0]        len;
    logic signed [DOT_W-1:0] dot_x;
    logic signed [DOT_W-1:0] dot_y;
  } front_t;

  // Sideband carried through the depth divider.
  typedef struct packed {
    logic                    culled;
    logic signed [DOT_W-1:0] dot_x;
    logic signed [DOT_W-1:0] dot_y;
  } dep_pl_t;

  typedef struct packed {
    logic                    culled;
    logic [DEPTH_W-1:0]      depth;
    logic signed [DOT_W-1:0] dot_x;
    logic signed [DOT_W-1:0] dot_y;
  } mul_in_t;

  // One screen axis after scaling by depth.
  typedef struct packed {
    logic             neg;
    logic             zero;
    logic [MUL_W-1:0] m;
  } lane_t;

  typedef struct packed {
    logic               culled;
    logic [DEPTH_W-1:0] depth;
    lane_t              x;
    lane_t              y;
  } mul_t;

  typedef struct packed {
    logic               culled;
    logic [DEPTH_W-1:0] depth;
    logic               neg;
    logic               zero;
  } ndcx_pl_t;

  typedef struct packed {
    logic neg;
    logic zero;
  } ndcy_pl_t;

  // Component k of a packed axis, x in the top bits.
  function automatic logic signed [AXIS_W-1:0] axis_comp(input logic [AXES_W-1:0] a,
                                                          input int unsigned k);
    return $signed(a[(2 - k) * AXIS_W +: AXIS_W]);
  endfunction

  // Saturate an unsigned quotient and apply the sign of the dot product.
  function automatic logic [CW-1:0] ndc_fix(input logic [NDC_QW-1:0] q, input logic ovf,
                                            input logic neg, input logic zero);
    logic              sat;
    logic [NDC_QW-1:0] mag;
    sat = ovf | (neg ? (q > NDC_HALF) : q[NDC_QW-1]);
    mag = sat ? (neg ? NDC_HALF : NDC_HALF - CW'(1)) : q;
    if (zero) begin
      return '0;
    end
    return neg ? (CW'(0) - mag) : mag;
  endfunction

endpackage

FILE: sv/world_point_perspective_projection.sv
// Top level of the world point perspective projection pipeline.
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_stall  point_x, point_y, point_z
//   out_     output     out_valid/out_stall ndc_x, ndc_y, depth, culled
//   cfg_     input      cfg_we             cfg_index, cfg_wdata
//
// One request per cycle while the output is not stalled. The pipe runs through
// the front end, depth divider, multiply, screen divider and output register.
// The two restoring dividers, one quotient bit per stage, set the pipe depth.
// Reset clears all valid bits and loads the register defaults.
// A stalled output holds the whole pipe; the input stage still takes a
// request when it is empty.
module world_point_perspective_projection (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  wppp_pkg::in_t                in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output wppp_pkg::out_t               out_data,
  input  logic                         cfg_we,
  input  wppp_pkg::cfg_idx_t           cfg_index,
  input  logic [wppp_pkg::CFG_W-1:0]   cfg_wdata
);
  import wppp_pkg::*;

  logic [CW-1:0]      origin_x_r, origin_y_r, origin_z_r;
  logic [AXES_W-1:0]  forward_r, up_r, right_r;
  logic [NEAR_W-1:0]  near_r;
  logic [PLANE_W-1:0] plane_r;

  logic               en, ld_ok;
  logic               front_v, dep_v, mul_v, x_v, y_v;
  front_t             front_data;
  dep_pl_t            dep_pl;
  logic [DEP_QW-1:0]  dep_q;
  logic               dep_ovf;
  logic [DEPTH_W-1:0] depth_c;
  mul_in_t            mul_in;
  mul_t               mul_data;
  logic [NDC_DW-1:0]  den_x, den_y;
  logic [NDC_QW-1:0]  qx, qy;
  logic               ovf_x, ovf_y;
  ndcx_pl_t           x_pl;
  ndcy_pl_t           y_pl;
  logic               out_valid_r;
  out_t               out_data_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
      origin_z_r <= '0;
      forward_r  <= FORWARD_RST;
      up_r       <= UP_RST;
      right_r    <= RIGHT_RST;
      near_r     <= NEAR_RST;
      plane_r    <= PLANE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ORIGIN_X: origin_x_r <= cfg_wdata[CW-1:0];
        CFG_ORIGIN_Y: origin_y_r <= cfg_wdata[CW-1:0];
        CFG_ORIGIN_Z: origin_z_r <= cfg_wdata[CW-1:0];
        CFG_FORWARD:  forward_r  <= cfg_wdata[AXES_W-1:0];
        CFG_UP:       up_r       <= cfg_wdata[AXES_W-1:0];
        CFG_RIGHT:    right_r    <= cfg_wdata[AXES_W-1:0];
        CFG_NEAR:     near_r     <= cfg_wdata[NEAR_W-1:0];
        CFG_PLANE:    plane_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The pipe advances unless a finished request is held at the output.
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !ld_ok;

  wppp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .ld_ok        (ld_ok),
    .in_v         (in_valid),
    .in_data      (in_data),
    .origin_x     (origin_x_r),
    .origin_y     (origin_y_r),
    .origin_z     (origin_z_r),
    .forward_axis (forward_r),
    .up_axis      (up_r),
    .right_axis   (right_r),
    .out_v        (front_v),
    .out_data     (front_data)
  );

  // Depth is near scaled up by the fraction bits over the forward length.
  wppp_div #(
    .HW (NEAR_W),
    .DW (MAG_W),
    .QW (DEP_QW),
    .PW ($bits(dep_pl_t))
  ) u_dep_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_v   (front_v),
    .num_hi (near_r),
    .num_lo ('0),
    .den    (front_data.len),
    .pl_in  ({front_data.culled, front_data.dot_x, front_data.dot_y}),
    .out_v  (dep_v),
    .q      (dep_q),
    .ovf    (dep_ovf),
    .pl_out (dep_pl)
  );

  // Saturate depth; a culled point gets zero depth, which zeroes both screen values.
  always_comb begin
    if (dep_pl.culled) begin
      depth_c = '0;
    end else if (dep_ovf || ((dep_q >> DEPTH_W) != '0)) begin
      depth_c = '1;
    end else begin
      depth_c = dep_q[DEPTH_W-1:0];
    end
  end

  assign mul_in.culled = dep_pl.culled;
  assign mul_in.depth  = depth_c;
  assign mul_in.dot_x  = dep_pl.dot_x;
  assign mul_in.dot_y  = dep_pl.dot_y;

  wppp_mul u_mul (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (dep_v),
    .in_data  (mul_in),
    .out_v    (mul_v),
    .out_data (mul_data)
  );

  // Half the plane size in the divisor: the doubling sits in the dividend.
  assign den_x = {plane_r[PLANE_W-1:SIZE_W], {AXIS_FRAC{1'b0}}};
  assign den_y = {plane_r[SIZE_W-1:0], {AXIS_FRAC{1'b0}}};

  wppp_div #(
    .HW (NDC_HW),
    .DW (NDC_DW),
    .QW (NDC_QW),
    .PW ($bits(ndcx_pl_t))
  ) u_x_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_v   (mul_v),
    .num_hi (mul_data.x.m[MUL_W-1:NDC_QW]),
    .num_lo (mul_data.x.m[NDC_QW-1:0]),
    .den    (den_x),
    .pl_in  ({mul_data.culled, mul_data.depth, mul_data.x.neg, mul_data.x.zero}),
    .out_v  (x_v),
    .q      (qx),
    .ovf    (ovf_x),
    .pl_out (x_pl)
  );

  wppp_div #(
    .HW (NDC_HW),
    .DW (NDC_DW),
    .QW (NDC_QW),
    .PW ($bits(ndcy_pl_t))
  ) u_y_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_v   (mul_v),
    .num_hi (mul_data.y.m[MUL_W-1:NDC_QW]),
    .num_lo (mul_data.y.m[NDC_QW-1:0]),
    .den    (den_y),
    .pl_in  ({mul_data.y.neg, mul_data.y.zero}),
    .out_v  (y_v),
    .q      (qy),
    .ovf    (ovf_y),
    .pl_out (y_pl)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= x_v && y_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r.ndc_x  <= ndc_fix(qx, ovf_x, x_pl.neg, x_pl.zero);
      out_data_r.ndc_y  <= ndc_fix(qy, ovf_y, y_pl.neg, y_pl.zero);
      out_data_r.depth  <= x_pl.depth;
      out_data_r.culled <= x_pl.culled;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: sv/wppp_front.sv
// Front end: origin subtraction, axis products and dot product sums.
module wppp_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  output logic                  ld_ok,
  input  logic                  in_v,
  input  wppp_pkg::in_t         in_data,
  input  logic [wppp_pkg::CW-1:0]     origin_x,
  input  logic [wppp_pkg::CW-1:0]     origin_y,
  input  logic [wppp_pkg::CW-1:0]     origin_z,
  input  logic [wppp_pkg::AXES_W-1:0] forward_axis,
  input  logic [wppp_pkg::AXES_W-1:0] up_axis,
  input  logic [wppp_pkg::AXES_W-1:0] right_axis,
  output logic                  out_v,
  output wppp_pkg::front_t      out_data
);
  import wppp_pkg::*;

  logic                     v_a_r, v_b_r, v_c_r;
  logic signed [CW-1:0]     pt  [0:2];
  logic signed [CW-1:0]     org [0:2];
  logic signed [DIFF_W-1:0] diff_r [0:2];
  logic signed [PROD_W-1:0] pf_r [0:2];
  logic signed [PROD_W-1:0] pr_r [0:2];
  logic signed [PROD_W-1:0] pu_r [0:2];
  logic signed [DOT_W-1:0]  len_r, dx_r, dy_r;

  assign pt[0]  = in_data.point_x;
  assign pt[1]  = in_data.point_y;
  assign pt[2]  = in_data.point_z;
  assign org[0] = $signed(origin_x);
  assign org[1] = $signed(origin_y);
  assign org[2] = $signed(origin_z);

  // The first stage may fill a bubble even while the rest of the pipe holds.
  assign ld_ok = en || !v_a_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r <= 1'b0;
      v_b_r <= 1'b0;
      v_c_r <= 1'b0;
    end else begin
      if (ld_ok) begin
        v_a_r <= in_v;
      end
      if (en) begin
        v_b_r <= v_a_r;
        v_c_r <= v_b_r;
      end
    end
  end

  // Offset from the camera origin.
  always_ff @(posedge clk) begin
    if (ld_ok) begin
      for (int k = 0; k < 3; k++) begin
        diff_r[k] <= DIFF_W'(pt[k]) - DIFF_W'(org[k]);
      end
    end
  end

  // One product per component and axis.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        pf_r[k] <= PROD_W'(diff_r[k]) * PROD_W'(axis_comp(forward_axis, k));
        pr_r[k] <= PROD_W'(diff_r[k]) * PROD_W'(axis_comp(right_axis, k));
        pu_r[k] <= PROD_W'(diff_r[k]) * PROD_W'(axis_comp(up_axis, k));
      end
    end
  end

  // Dot product sums.
  always_ff @(posedge clk) begin
    if (en) begin
      len_r <= DOT_W'(pf_r[0]) + DOT_W'(pf_r[1]) + DOT_W'(pf_r[2]);
      dx_r  <= DOT_W'(pr_r[0]) + DOT_W'(pr_r[1]) + DOT_W'(pr_r[2]);
      dy_r  <= DOT_W'(pu_r[0]) + DOT_W'(pu_r[1]) + DOT_W'(pu_r[2]);
    end
  end

  // A point on or behind the camera plane is culled.
  assign out_v           = v_c_r;
  assign out_data.culled = len_r[DOT_W-1] | (len_r == '0);
  assign out_data.len    = len_r[MAG_W-1:0];
  assign out_data.dot_x  = dx_r;
  assign out_data.dot_y  = dy_r;

endmodule

FILE: sv/wppp_div.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow detect.
module wppp_div #(
  parameter int HW = 32,
  parameter int DW = 32,
  parameter int QW = 32,
  parameter int PW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_v,
  input  logic [HW-1:0] num_hi,
  input  logic [QW-1:0] num_lo,
  input  logic [DW-1:0] den,
  input  logic [PW-1:0] pl_in,
  output logic          out_v,
  output logic [QW-1:0] q,
  output logic          ovf,
  output logic [PW-1:0] pl_out
);
  localparam int MW = (HW > DW) ? HW : DW;

  logic [MW-1:0] hi_ext, den_ext;
  logic [DW-1:0] rem_r [0:QW-1];
  logic [DW-1:0] dv_r  [0:QW-1];
  logic [QW-1:0] lo_r  [0:QW];
  logic          ovf_r [0:QW];
  logic [PW-1:0] pl_r  [0:QW];
  logic          v_r   [0:QW];

  assign hi_ext  = MW'(num_hi);
  assign den_ext = MW'(den);

  // Entry stage: the quotient overflows its width when the high part reaches the divisor.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= hi_ext[DW-1:0];
      dv_r[0]  <= den;
      lo_r[0]  <= num_lo;
      ovf_r[0] <= hi_ext >= den_ext;
      pl_r[0]  <= pl_in;
    end
  end

  // One shift and conditional subtract per stage.
  for (genvar i = 1; i <= QW; i++) begin : g_step
    logic [DW:0] shf_nxt;
    logic        ge;

    assign shf_nxt = {rem_r[i-1], lo_r[i-1][QW-1]};
    assign ge      = shf_nxt >= {1'b0, dv_r[i-1]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= v_r[i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        lo_r[i]  <= {lo_r[i-1][QW-2:0], ge};
        ovf_r[i] <= ovf_r[i-1];
        pl_r[i]  <= pl_r[i-1];
      end
    end

    if (i < QW) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[i] <= ge ? DW'(shf_nxt - {1'b0, dv_r[i-1]}) : shf_nxt[DW-1:0];
          dv_r[i]  <= dv_r[i-1];
        end
      end
    end
  end

  assign out_v  = v_r[QW];
  assign q      = lo_r[QW];
  assign ovf    = ovf_r[QW];
  assign pl_out = pl_r[QW];

endmodule

FILE: sv/wppp_mul.sv
// Scales both screen dot products by depth in two split partial products.
module wppp_mul (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_v,
  input  wppp_pkg::mul_in_t in_data,
  output logic              out_v,
  output wppp_pkg::mul_t    out_data
);
  import wppp_pkg::*;

  localparam int LO_W  = MAG_W / 2;
  localparam int HI_W  = MAG_W - LO_W;
  localparam int SUM_W = MAG_W + DEPTH_W;

  logic                    v1_r, v2_r, v3_r;
  logic signed [DOT_W-1:0] dot [0:1];
  logic [MAG_W-1:0]        mag1_r [0:1];
  logic                    neg1_r [0:1];
  logic                    zero1_r [0:1];
  logic [LO_W+DEPTH_W-1:0] plo_r [0:1];
  logic [HI_W+DEPTH_W-1:0] phi_r [0:1];
  logic                    neg2_r [0:1];
  logic                    zero2_r [0:1];
  logic [MUL_W-1:0]        m3_r [0:1];
  logic                    neg3_r [0:1];
  logic                    zero3_r [0:1];
  logic [DEPTH_W-1:0]      dep1_r, dep2_r, dep3_r;
  logic                    cul1_r, cul2_r, cul3_r;

  assign dot[0] = in_data.dot_x;
  assign dot[1] = in_data.dot_y;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_v;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // Sign and magnitude; a zero product is flagged for the output mapping.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 2; k++) begin
        neg1_r[k]  <= dot[k][DOT_W-1];
        mag1_r[k]  <= MAG_W'(dot[k][DOT_W-1] ? (DOT_W'(0) - dot[k]) : dot[k]);
        zero1_r[k] <= (dot[k] == '0) || (in_data.depth == '0);
      end
      dep1_r <= in_data.depth;
      cul1_r <= in_data.culled;
    end
  end

  // Partial products of the low and high halves.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 2; k++) begin
        plo_r[k]   <= (LO_W + DEPTH_W)'(mag1_r[k][LO_W-1:0]) * (LO_W + DEPTH_W)'(dep1_r);
        phi_r[k]   <= (HI_W + DEPTH_W)'(mag1_r[k][MAG_W-1:LO_W]) * (HI_W + DEPTH_W)'(dep1_r);
        neg2_r[k]  <= neg1_r[k];
        zero2_r[k] <= zero1_r[k];
      end
      dep2_r <= dep1_r;
      cul2_r <= cul1_r;
    end
  end

  // Recombine and double.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 2; k++) begin
        m3_r[k]    <= {(SUM_W'(phi_r[k]) << LO_W) + SUM_W'(plo_r[k]), 1'b0};
        neg3_r[k]  <= neg2_r[k];
        zero3_r[k] <= zero2_r[k];
      end
      dep3_r <= dep2_r;
      cul3_r <= cul2_r;
    end
  end

  assign out_v           = v3_r;
  assign out_data.culled = cul3_r;
  assign out_data.depth  = dep3_r;
  assign out_data.x.neg  = neg3_r[0];
  assign out_data.x.zero = zero3_r[0];
  assign out_data.x.m    = m3_r[0];
  assign out_data.y.neg  = neg3_r[1];
  assign out_data.y.zero = zero3_r[1];
  assign out_data.y.m    = m3_r[1];

endmodule

FILE: sv/wppp_checker.sv
// Port-level checks of the perspective projection block and their binding.
`include "world_point_perspective_projection_defines.svh"

module wppp_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_stall,
  input logic           out_valid,
  input logic           out_stall,
  input wppp_pkg::out_t out_data
);

  // The input only stalls behind a held result.
  `WPPP_ASSERT(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall)

  // A culled point reports all zero values.
  `WPPP_ASSERT(a_culled_zero, clk, rst_n, out_valid && out_data.culled, (out_data.ndc_x == '0) && (out_data.ndc_y == '0) && (out_data.depth == '0))

  // A held result stays in place.
  `WPPP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))

endmodule

bind world_point_perspective_projection wppp_checker u_wppp_checker (.*);
